>>> sv/sphere_capsule_contact_defines.svh
// Assertion macros shared by the sphere against capsule contact block.
// Needs nothing else; included by sphere_capsule_contact.sv, which carries the assertions.
`ifndef SPHERE_CAPSULE_CONTACT_DEFINES_SVH
`define SPHERE_CAPSULE_CONTACT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/scc_pkg.sv
// Constants and types for the sphere against capsule contact block.
// Depends on nothing; used by sphere_capsule_contact.
`default_nettype none

package scc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// How the segment parameter t is chosen.
	typedef enum logic [1:0] {
		T_ZERO,
		T_ONE,
		T_DIV
	} tsel_t;

endpackage

`default_nettype wire

>>> sv/sphere_capsule_contact.sv
// Sphere against capsule contact test, fully pipelined. Each request carries a
// sphere and a capsule in signed fixed point; the block answers with hit,
// contact midpoint, unit normal and penetration, zeros on a miss. One request
// is taken every cycle while no finished result is held back; a request
// passes through the bit-per-stage divider for the segment parameter, the
// bit-per-stage square root of the squared distance and the bit-per-stage
// normal dividers. The whole pipeline holds while a finished result is not
// taken.
// Depends on scc_pkg and sphere_capsule_contact_defines.svh.
`default_nettype none
`include "sphere_capsule_contact_defines.svh"

module sphere_capsule_contact #(
	parameter int COORD_WIDTH = scc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = scc_pkg::FRAC_BITS,
	localparam int IN_BITS    = 11 * COORD_WIDTH - 2,
	localparam int IN_TW      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = 2 + 4 * COORD_WIDTH + 3 * (FRAC_BITS + 2),
	localparam int OUT_TW     = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// sphere_x, sphere_y, sphere_z, seg_start_x, seg_start_y, seg_start_z,
	// seg_end_x, seg_end_y, seg_end_z, sph_rad, cap_rad
	input  wire logic [IN_TW-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// hit, contact_x, contact_y, contact_z, normal_x, normal_y, normal_z,
	// normal_valid, penetration
	output logic [OUT_TW-1:0]      m_tdata
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int NW  = F + 2;
	localparam int DW  = CW + 1;
	localparam int LW  = 2 * DW + 1;
	localparam int PW  = 2 * DW + 2;
	localparam int PRW = DW + F + 2;
	localparam int QW  = 2 * CW + 2;
	localparam int RW  = CW + 1;
	localparam int SRW = CW + 4;
	localparam int NS  = 2 * F + RW + 9;

	typedef struct packed {
		logic [2:0][CW-1:0] c;
		logic [2:0][CW-1:0] a;
		logic [2:0][DW-1:0] d;
		logic [CW-1:0]      rsum;
	} geo_t;

	typedef struct packed {
		geo_t              g;
		logic [2*CW-1:0]   rsum2;
		logic [LW-1:0]     len2;
		scc_pkg::tsel_t    tsel;
		logic [LW-1:0]     rem;
		logic [F-1:0]      quo;
	} tdiv_t;

	typedef struct packed {
		logic [2:0][CW-1:0]  c;
		logic [2:0][CW-1:0]  a;
		logic [CW-1:0]       rsum;
		logic [2*CW-1:0]     rsum2;
		logic [2:0][PRW-1:0] prod;
	} tm_t;

	typedef struct packed {
		logic [2:0][CW-1:0] ctc;
		logic [2:0][CW-1:0] mag;
		logic [2:0]         neg;
		logic [CW-1:0]      rsum;
		logic [2*CW-1:0]    rsum2;
	} nr_t;

	typedef struct packed {
		nr_t                  n;
		logic [2:0][2*CW-1:0] sq;
	} sqm_t;

	typedef struct packed {
		logic [2:0][CW-1:0] ctc;
		logic [2:0][CW-1:0] mag;
		logic [2:0]         neg;
		logic [CW-1:0]      rsum;
		logic               hit;
		logic [QW-1:0]      dist2;
		logic [SRW-1:0]     rem;
		logic [RW-1:0]      root;
	} rt_t;

	typedef struct packed {
		logic [2:0][CW-1:0] ctc;
		logic [2:0]         neg;
		logic [CW-1:0]      rsum;
		logic               hit;
		logic [RW-1:0]      droot;
		logic [2:0][RW-1:0] rem;
		logic [2:0][F:0]    quo;
	} nd_t;

	typedef struct packed {
		logic [CW-1:0]      pen;
		logic               nvalid;
		logic [2:0][NW-1:0] nrm;
		logic [2:0][CW-1:0] ctc;
		logic               hit;
	} out_t;

	logic          en;
	logic [NS-1:0] v_q;

	geo_t                 g_s0, g_nx0;
	logic [2:0][DW-1:0]   w_s0, w_nx0;
	geo_t                 g_s1;
	logic [2:0][2*DW-1:0] dd_s1, dd_nx1, wd_s1, wd_nx1;
	logic [2*CW-1:0]      rs2_s1, rs2_nx1;
	tdiv_t                td_s [F+1];
	tdiv_t                td_in;
	tdiv_t                td_nx [F];
	tm_t                  tm_s, tm_nx;
	nr_t                  nr_s, nr_nx;
	sqm_t                 sqm_s, sqm_nx;
	rt_t                  rt_s [RW+1];
	rt_t                  rt_in;
	rt_t                  rt_nx [RW];
	nd_t                  nd_in;
	nd_t                  nd_src [F+1];
	nd_t                  nd_nx [F+1];
	nd_t                  nd_s [F+1];
	out_t                 out_s, out_nx;

	// The pipeline moves as one; a held result stops every stage.
	assign en       = !v_q[NS-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[NS-1];
	assign m_tdata  = OUT_TW'(out_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], s_tvalid};
		end
	end

	// Stage 0: unpack, segment direction, centre offset and radius sum.
	always_comb begin
		logic [CW-1:0] cc, aa, bb;
		logic [CW-2:0] sr, cr;
		for (int k = 0; k < 3; k++) begin
			cc = s_tdata[k*CW +: CW];
			aa = s_tdata[(3+k)*CW +: CW];
			bb = s_tdata[(6+k)*CW +: CW];
			g_nx0.c[k] = cc;
			g_nx0.a[k] = aa;
			g_nx0.d[k] = {bb[CW-1], bb} - {aa[CW-1], aa};
			w_nx0[k]   = {cc[CW-1], cc} - {aa[CW-1], aa};
		end
		sr = s_tdata[9*CW +: CW-1];
		cr = s_tdata[10*CW-1 +: CW-1];
		g_nx0.rsum = {1'b0, sr} + {1'b0, cr};
	end

	// Stage 1: squares of the direction, projection products, radius sum squared.
	always_comb begin
		logic signed [2*DW-1:0] pd, pw;
		for (int k = 0; k < 3; k++) begin
			pd = $signed(g_s0.d[k]) * $signed(g_s0.d[k]);
			pw = $signed(w_s0[k]) * $signed(g_s0.d[k]);
			dd_nx1[k] = pd;
			wd_nx1[k] = pw;
		end
		rs2_nx1 = g_s0.rsum * g_s0.rsum;
	end

	// Stage 2: length squared, dot product and the choice of t.
	always_comb begin
		logic [LW-1:0] len2;
		logic [PW-1:0] dot;
		len2 = '0;
		dot  = '0;
		for (int k = 0; k < 3; k++) begin
			len2 = len2 + {1'b0, dd_s1[k]};
			dot  = dot + {{2{wd_s1[k][2*DW-1]}}, wd_s1[k]};
		end
		td_in.g     = g_s1;
		td_in.rsum2 = rs2_s1;
		td_in.len2  = len2;
		td_in.rem   = dot[LW-1:0];
		td_in.quo   = '0;
		priority if (len2 == '0 || dot[PW-1] || dot == '0) begin
			td_in.tsel = scc_pkg::T_ZERO;
		end else if ($signed(dot) >= $signed({1'b0, len2})) begin
			td_in.tsel = scc_pkg::T_ONE;
		end else begin
			td_in.tsel = scc_pkg::T_DIV;
		end
	end

	// Restoring divider for t, one quotient bit per stage.
	always_comb begin
		logic [LW:0] rs;
		logic        ge;
		for (int j = 0; j < F; j++) begin
			td_nx[j]     = td_s[j];
			rs           = {td_s[j].rem, 1'b0};
			ge           = rs >= {1'b0, td_s[j].len2};
			td_nx[j].rem = ge ? LW'(rs - {1'b0, td_s[j].len2}) : rs[LW-1:0];
			td_nx[j].quo = {td_s[j].quo[F-2:0], ge};
		end
	end

	// Scale the direction by t.
	always_comb begin
		logic [F:0]              t;
		logic signed [PRW-1:0]   p;
		unique case (td_s[F].tsel)
			scc_pkg::T_ZERO: t = '0;
			scc_pkg::T_ONE:  t = {1'b1, {F{1'b0}}};
			scc_pkg::T_DIV:  t = {1'b0, td_s[F].quo};
			default:         t = '0;
		endcase
		tm_nx.c     = td_s[F].g.c;
		tm_nx.a     = td_s[F].g.a;
		tm_nx.rsum  = td_s[F].g.rsum;
		tm_nx.rsum2 = td_s[F].rsum2;
		for (int k = 0; k < 3; k++) begin
			p = $signed(td_s[F].g.d[k]) * $signed({1'b0, t});
			tm_nx.prod[k] = p;
		end
	end

	// Nearest point, offset from it to the centre, and the contact midpoint.
	always_comb begin
		logic signed [PRW-1:0] sh, nrf;
		logic [CW:0]           nr;
		logic [CW+1:0]         dfv, magv, sm;
		for (int k = 0; k < 3; k++) begin
			sh  = $signed(tm_s.prod[k]) >>> F;
			nrf = $signed({{(PRW-CW){tm_s.a[k][CW-1]}}, tm_s.a[k]}) + sh;
			nr  = nrf[CW:0];
			dfv = {{2{tm_s.c[k][CW-1]}}, tm_s.c[k]} - {nr[CW], nr};
			magv = dfv[CW+1] ? (~dfv + 1'b1) : dfv;
			sm  = {nr[CW], nr} + {{2{tm_s.c[k][CW-1]}}, tm_s.c[k]};
			nr_nx.neg[k] = dfv[CW+1];
			nr_nx.mag[k] = magv[CW-1:0];
			nr_nx.ctc[k] = sm[CW:1];
		end
		nr_nx.rsum  = tm_s.rsum;
		nr_nx.rsum2 = tm_s.rsum2;
	end

	always_comb begin
		sqm_nx.n = nr_s;
		for (int k = 0; k < 3; k++) begin
			sqm_nx.sq[k] = nr_s.mag[k] * nr_s.mag[k];
		end
	end

	// Squared distance and the overlap test; the root starts from zero.
	always_comb begin
		logic [QW-1:0] d2;
		d2 = '0;
		for (int k = 0; k < 3; k++) begin
			d2 = d2 + {2'b00, sqm_s.sq[k]};
		end
		rt_in.ctc   = sqm_s.n.ctc;
		rt_in.mag   = sqm_s.n.mag;
		rt_in.neg   = sqm_s.n.neg;
		rt_in.rsum  = sqm_s.n.rsum;
		rt_in.hit   = d2 < {2'b00, sqm_s.n.rsum2};
		rt_in.dist2 = d2;
		rt_in.rem   = '0;
		rt_in.root  = '0;
	end

	// Integer square root, one root bit per stage from the top pair down.
	always_comb begin
		logic [SRW-1:0] remsh, test;
		logic           ge;
		for (int i = 0; i < RW; i++) begin
			rt_nx[i]      = rt_s[i];
			remsh         = {rt_s[i].rem[SRW-3:0], rt_s[i].dist2[2*(RW-1-i) +: 2]};
			test          = SRW'({rt_s[i].root, 2'b01});
			ge            = remsh >= test;
			rt_nx[i].rem  = ge ? (remsh - test) : remsh;
			rt_nx[i].root = {rt_s[i].root[RW-2:0], ge};
		end
	end

	// Normal division: each offset magnitude is at most the distance, so the
	// first stage takes the integer bit without a shift.
	always_comb begin
		nd_in.ctc   = rt_s[RW].ctc;
		nd_in.neg   = rt_s[RW].neg;
		nd_in.rsum  = rt_s[RW].rsum;
		nd_in.hit   = rt_s[RW].hit;
		nd_in.droot = rt_s[RW].root;
		nd_in.quo   = '0;
		for (int k = 0; k < 3; k++) begin
			nd_in.rem[k] = RW'(rt_s[RW].mag[k]);
		end
		nd_src[0] = nd_in;
		for (int i = 1; i <= F; i++) begin
			nd_src[i] = nd_s[i-1];
		end
	end

	always_comb begin
		logic [RW:0] rs;
		logic        ge;
		for (int i = 0; i <= F; i++) begin
			nd_nx[i] = nd_src[i];
			for (int k = 0; k < 3; k++) begin
				rs = (i == 0) ? {1'b0, nd_src[i].rem[k]} : {nd_src[i].rem[k], 1'b0};
				ge = rs >= {1'b0, nd_src[i].droot};
				nd_nx[i].rem[k] = ge ? RW'(rs - {1'b0, nd_src[i].droot}) : rs[RW-1:0];
				nd_nx[i].quo[k] = {nd_src[i].quo[k][F-1:0], ge};
			end
		end
	end

	// Result assembly; a miss clears every field.
	always_comb begin
		logic [NW-1:0] q;
		logic          nv;
		nv = nd_s[F].droot != '0;
		out_nx.hit    = nd_s[F].hit;
		out_nx.nvalid = nd_s[F].hit && nv;
		out_nx.pen    = nd_s[F].hit ? (nd_s[F].rsum - nd_s[F].droot[CW-1:0]) : '0;
		for (int k = 0; k < 3; k++) begin
			q = {1'b0, nd_s[F].quo[k]};
			out_nx.ctc[k] = nd_s[F].hit ? nd_s[F].ctc[k] : '0;
			if (nd_s[F].hit && nv) begin
				out_nx.nrm[k] = nd_s[F].neg[k] ? (~q + 1'b1) : q;
			end else begin
				out_nx.nrm[k] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s0   <= g_nx0;
			w_s0   <= w_nx0;
			g_s1   <= g_s0;
			dd_s1  <= dd_nx1;
			wd_s1  <= wd_nx1;
			rs2_s1 <= rs2_nx1;
			td_s[0] <= td_in;
			for (int j = 0; j < F; j++) begin
				td_s[j+1] <= td_nx[j];
			end
			tm_s  <= tm_nx;
			nr_s  <= nr_nx;
			sqm_s <= sqm_nx;
			rt_s[0] <= rt_in;
			for (int i = 0; i < RW; i++) begin
				rt_s[i+1] <= rt_nx[i];
			end
			for (int i = 0; i <= F; i++) begin
				nd_s[i] <= nd_nx[i];
			end
			out_s <= out_nx;
		end
	end

	`SCC_ASSERT_IMP(a_idle_ready, clk, arst_n, !m_tvalid, s_tready,
		"pipeline refused a request while no result was held")
	`SCC_ASSERT_NXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, v_q[0],
		"accepted request did not enter the first stage")
	`SCC_ASSERT_IMP(a_miss_clear, clk, arst_n, m_tvalid && !out_s.hit,
		out_s.pen == '0 && !out_s.nvalid && out_s.ctc == '0 && out_s.nrm == '0,
		"miss result carries non-zero fields")
	`SCC_ASSERT_IMP(a_hit_pen, clk, arst_n, m_tvalid && out_s.hit, out_s.pen != '0,
		"hit result with zero penetration")

endmodule

`default_nettype wire

>>> dv/tb_sphere_capsule_contact.sv
// Self-checking bench for sphere_capsule_contact: directed pairs, then random pairs.
// Expected contacts come from a local fixed-point predictor; depends on scc_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_sphere_capsule_contact;

	localparam int  Q_ONE    = 1 << scc_pkg::FRAC_BITS;
	localparam int  N_RANDOM = 1500;

	typedef struct packed {
		logic [30:0]        cap_r;
		logic [30:0]        sph_r;
		logic signed [31:0] bz, by, bx, az, ay, ax, cz, cy, cx;
	} pair_t;

	typedef struct packed {
		logic [31:0]        pen;
		logic               nvalid;
		logic signed [17:0] nz, ny, nx;
		logic signed [31:0] pz, py, px;
		logic               hit;
	} contact_t;

	typedef struct {
		pair_t    p;
		bit       known;
		contact_t r;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [351:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [183:0] m_tdata;

	contact_t pending_contacts[$];
	int       n_errors = 0;
	int       n_hits = 0;
	int       n_results = 0;
	int       cyc = 0;

	sphere_capsule_contact i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [127:0] rem, test, root;
		rem = '0;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | n[2*i +: 2];
			test = (root << 2) | 128'd1;
			root = root << 1;
			if (rem >= test) begin
				rem = rem - test;
				root = root | 128'd1;
			end
		end
		return root;
	endfunction

	function automatic contact_t contact_of(pair_t p);
		logic signed [127:0] c[3], a[3], b[3], d[3], w[3], nr[3], df[3];
		logic signed [127:0] len2, dot, dist2, t, rsum, rsum2, dlen, mid, q;
		contact_t r;
		c = '{p.cx, p.cy, p.cz};
		a = '{p.ax, p.ay, p.az};
		b = '{p.bx, p.by, p.bz};
		len2 = 0;
		dot = 0;
		dist2 = 0;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			d[k] = b[k] - a[k];
			w[k] = c[k] - a[k];
			len2 = len2 + d[k] * d[k];
			dot = dot + w[k] * d[k];
		end
		if (len2 == 0 || dot <= 0)
			t = 0;
		else if (dot >= len2)
			t = Q_ONE;
		else
			t = (dot <<< scc_pkg::FRAC_BITS) / len2;
		for (int k = 0; k < 3; k++) begin
			nr[k] = a[k] + ((d[k] * t) >>> scc_pkg::FRAC_BITS);
			df[k] = c[k] - nr[k];
			dist2 = dist2 + df[k] * df[k];
		end
		rsum = 128'(p.sph_r) + 128'(p.cap_r);
		rsum2 = rsum * rsum;
		if (dist2 >= rsum2)
			return r;
		dlen = isqrt(dist2);
		r.hit = 1'b1;
		r.nvalid = dlen != 0;
		r.pen = 32'(rsum - dlen);
		for (int k = 0; k < 3; k++) begin
			mid = (nr[k] + c[k]) >>> 1;
			q = 0;
			if (dlen != 0) begin
				q = ((df[k] < 0 ? -df[k] : df[k]) <<< scc_pkg::FRAC_BITS) / dlen;
				if (df[k] < 0)
					q = -q;
			end
			case (k)
				0: begin r.px = 32'(mid); r.nx = 18'(q); end
				1: begin r.py = 32'(mid); r.ny = 18'(q); end
				default: begin r.pz = 32'(mid); r.nz = 18'(q); end
			endcase
		end
		return r;
	endfunction

	function automatic pair_t mk(int cx, int cy, int cz, int ax, int ay, int az,
			int bx, int by, int bz, logic [30:0] rs, logic [30:0] rc);
		pair_t p;
		p = '{rc, rs, bz, by, bx, az, ay, ax, cz, cy, cx};
		return p;
	endfunction

	// Small offsets keep most random pairs close enough to touch.
	function automatic logic [31:0] near(logic [31:0] base, int span);
		return base + $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		logic [31:0] o;
		int span;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			p = 350'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom});
			return p;
		end
		span = 1 << $urandom_range(4, 22);
		o = (mode == 2) ? $urandom : $urandom_range(0, 1 << 24) - (1 << 23);
		p.ax = near(o, span);
		p.ay = near(o, span);
		p.az = near(o, span);
		if (mode == 3) begin
			p.bx = p.ax;
			p.by = p.ay;
			p.bz = p.az;
		end else begin
			p.bx = near(p.ax, span);
			p.by = near(p.ay, span);
			p.bz = near(p.az, span);
		end
		if (mode == 4) begin
			p.cx = p.ax;
			p.cy = p.ay;
			p.cz = p.az;
		end else begin
			p.cx = near(p.ax, 2 * span);
			p.cy = near(p.ay, 2 * span);
			p.cz = near(p.az, 2 * span);
		end
		p.sph_r = 31'($urandom_range(0, 2 * span));
		p.cap_r = 31'($urandom_range(0, 2 * span));
		return p;
	endfunction

	task automatic send(pair_t p, contact_t want);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, p};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_contacts.push_back(want);
	endtask

	task automatic send_pair(pair_t p);
		send(p, contact_of(p));
	endtask

	// The sender works in bursts and drops valid for a random gap in between.
	int burst_left = 0;
	task automatic maybe_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 40);
		gap = $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		row_t rows[$];
		row_t rw;
		contact_t z;
		z = '0;
		// Sphere centred on a zero-length capsule: a hit with no usable normal.
		rw.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, Q_ONE, Q_ONE);
		rw.known = 1;
		rw.r = z;
		rw.r.hit = 1'b1;
		rw.r.pen = 2 * Q_ONE;
		rows.push_back(rw);
		// Exact touch counts as a miss.
		rw.p = mk(2 * Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, Q_ONE, Q_ONE);
		rw.r = z;
		rows.push_back(rw);
		// Zero radii with the centre on the segment: still not below zero.
		rw.p = mk(Q_ONE, 0, 0, 0, 0, 0, 2 * Q_ONE, 0, 0, 0, 0);
		rows.push_back(rw);
		rw.p = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
		rows.push_back(rw);
		rw.known = 0;
		rw.p = mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, '1, '1);
		rows.push_back(rw);
		rw.p = mk(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000,
			32'h80000000, 0, 32'h80000000, '1, '1);
		rows.push_back(rw);
		rw.p = mk(0, 3 * Q_ONE, 0, -Q_ONE, 0, 0, Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE);
		rows.push_back(rw);
		rw.p = mk(0, 0, -3 * Q_ONE, -Q_ONE, 0, 0, Q_ONE, 0, 0, 2 * Q_ONE, 2 * Q_ONE);
		rows.push_back(rw);
		rw.p = mk(-5 * Q_ONE, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 3 * Q_ONE, 3 * Q_ONE);
		rows.push_back(rw);
		rw.p = mk(5 * Q_ONE, -Q_ONE, 7, 0, 0, 0, Q_ONE, 0, 0, 3 * Q_ONE, 3 * Q_ONE);
		rows.push_back(rw);
		rw.p = mk(12345, -6789, 99999, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, 2 * Q_ONE,
			3 * Q_ONE, Q_ONE, Q_ONE / 3);
		rows.push_back(rw);
		rw.p = mk(-1, -1, -1, 0, 0, 0, 0, 0, 0, 1, 1);
		rows.push_back(rw);
		rw.p = mk(-3, 1, 0, -1, -1, -1, 1, 1, 1, 5, 0);
		rows.push_back(rw);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].p, rows[i].known ? rows[i].r : contact_of(rows[i].p));
		for (int i = 0; i < N_RANDOM; i++) begin
			maybe_gap();
			// Let the pipeline drain completely once, half way through.
			if (i == N_RANDOM / 2) begin
				s_tvalid <= 1'b0;
				while (pending_contacts.size() != 0)
					@(posedge clk);
			end
			send_pair(random_pair());
		end
		s_tvalid <= 1'b0;
		while (pending_contacts.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		$display("Checked %0d contact results, %0d of them hits, over directed and random pairs.",
			n_results, n_hits);
		if (n_errors == 0 && pending_contacts.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The receiver stalls in phases: none, light, heavy, none.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case (cyc[9:8])
			2'd1: m_tready <= $urandom_range(0, 99) >= 30;
			2'd2: m_tready <= $urandom_range(0, 99) >= 75;
			default: m_tready <= 1'b1;
		endcase
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		contact_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			n_results++;
			if (pending_contacts.size() == 0) begin
				$error("result with no request outstanding");
				n_errors++;
			end else begin
				want = pending_contacts.pop_front();
				n_hits += want.hit;
				check_field("hit", want.hit, got.hit);
				check_field("contact_x", want.px, got.px);
				check_field("contact_y", want.py, got.py);
				check_field("contact_z", want.pz, got.pz);
				check_field("normal_x", want.nx, got.nx);
				check_field("normal_y", want.ny, got.ny);
				check_field("normal_z", want.nz, got.nz);
				check_field("normal_valid", want.nvalid, got.nvalid);
				check_field("penetration", want.pen, got.pen);
			end
		end
	end

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/scc_pkg.sv
sv/sphere_capsule_contact.sv
dv/tb_sphere_capsule_contact.sv
